@@ rtl/hse_pkg.sv @@
package hse_pkg;

  localparam int COUNT_BITS = 28;
  localparam int FRAC_BITS  = 16;
  localparam int LOG_FRAC   = FRAC_BITS + 2;
  localparam int TOTAL_BITS = 40;
  localparam int SUM_BITS   = 64;
  localparam int ENT_BITS   = 20;
  localparam int LOG_BITS   = 6 + LOG_FRAC;

  typedef struct packed {
    logic [27:0] bin_value;
    logic        is_last_bin;
  } hse_in_t;

  typedef struct packed {
    logic [19:0] entropy_bits;
    logic [39:0] total_count;
    logic        empty_hist;
  } hse_out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOG_NORM,
    ST_LOG_SQ,
    ST_MUL,
    ST_ACC,
    ST_CHECK,
    ST_DIV,
    ST_FLOG_NORM,
    ST_FLOG_SQ,
    ST_DONE
  } hse_state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
  } hse_log_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [LOG_BITS-1:0] result;
  } hse_log_rsp_t;

endpackage

@@ rtl/hse_log2.sv @@
module hse_log2 (
  input  logic                 clk,
  input  logic                 rst,
  input  hse_pkg::hse_log_req_t req,
  output hse_pkg::hse_log_rsp_t rsp
);
  import hse_pkg::*;

  logic [5:0]          expo;
  logic [32:0]         mant;
  logic [LOG_FRAC-1:0] frac;
  logic [4:0]          step;
  logic                running;
  logic                done;
  logic [5:0]          top_bit;
  logic [65:0]         sq;

  // leading one search over the operand
  always_comb begin
    top_bit = 6'd0;
    for (int i = 0; i < 64; i++) begin
      if (req.x[i]) top_bit = 6'(i);
    end
  end

  assign sq = 66'(mant) * 66'(mant);

  // one squaring per cycle, fraction bit by bit
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start && !running) begin
        running <= 1'b1;
        expo    <= top_bit;
        step    <= 5'd0;
        frac    <= '0;
        if (top_bit <= 6'd31) mant <= 33'(req.x << (6'd31 - top_bit));
        else mant <= 33'(req.x >> (top_bit - 6'd31));
      end else if (running) begin
        if (sq[65:31] >= 35'h1_0000_0000) begin
          mant <= 33'(sq[65:32]);
          frac <= {frac[LOG_FRAC-2:0], 1'b1};
        end else begin
          mant <= sq[63:31];
          frac <= {frac[LOG_FRAC-2:0], 1'b0};
        end
        step <= step + 5'd1;
        if (step == 5'(LOG_FRAC - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy   = running;
  assign rsp.done   = done;
  assign rsp.result = {expo, frac};

endmodule

@@ rtl/hse_divider.sv @@
module hse_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [39:0] divisor,
  output logic        done,
  output logic [63:0] quotient
);
  import hse_pkg::*;

  logic [40:0] rem;
  logic [63:0] quo;
  logic [6:0]  cnt;
  logic        running;
  logic [41:0] trial;

  assign trial = {rem, quo[63]} - {2'b00, divisor};

  // restoring division, one quotient bit per cycle
  // a start held into the done cycle does not launch a second pass
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start && !running && !done) begin
        running <= 1'b1;
        rem     <= '0;
        quo     <= dividend;
        cnt     <= '0;
      end else if (running) begin
        if (!trial[41]) begin
          rem <= trial[40:0];
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= {rem[39:0], quo[63]};
          quo <= {quo[62:0], 1'b0};
        end
        cnt <= cnt + 7'd1;
        if (cnt == 7'd63) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

@@ rtl/histogram_shannon_entropy.sv @@
// Shannon entropy of a histogram, one bin count per word.
// Input: pulse start with in_word while busy is low; is_last_bin marks the
// final bin. A zero bin that is not the last goes back to idle after the
// check; a nonzero bin runs an 18-step iterative log2 in the shared log2
// squaring unit, then one multiply and one accumulate.
// On a last bin the block also runs a restoring divide for S/N and a
// second log2 of N, then shows the result word on out_word for one cycle
// with done high. busy stays high until then.
// Output: entropy in Q4.16 bits, total count, and an empty flag; an empty
// histogram gives entropy 0 with the flag set, without the divide or log2.
// The receiver cannot stall: done is a one-cycle strobe.
// Reset clears the accumulators and returns to idle; the first word may
// be taken on the cycle after reset drops.
module histogram_shannon_entropy (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  hse_pkg::hse_in_t  in_word,
  output logic              busy,
  output logic              done,
  output hse_pkg::hse_out_t out_word
);
  import hse_pkg::*;

  hse_state_t          state, state_next;
  logic [39:0]         n_acc;
  logic [63:0]         s_acc;
  logic [27:0]         cnt;
  logic                last;
  logic [LOG_BITS-1:0] lg;
  logic [63:0]         term;
  logic [63:0]         quo_r;
  hse_log_req_t        lreq;
  hse_log_rsp_t        lrsp;
  logic                div_start, div_done;
  logic [63:0]         quo;
  logic [64:0]         s_sum;
  logic [40:0]         n_sum;
  logic [63:0]         h_raw;
  logic [63:0]         h_rnd;

  hse_log2 u_log (.clk(clk), .rst(rst), .req(lreq), .rsp(lrsp));

  hse_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(s_acc),
    .divisor(n_acc), .done(div_done), .quotient(quo)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (start) state_next = ST_CHECK;
      ST_CHECK: begin
        if (cnt != '0) state_next = ST_LOG_NORM;
        else if (!last) state_next = ST_IDLE;
        else if (n_acc == '0) state_next = ST_DONE;
        else state_next = ST_DIV;
      end
      ST_LOG_NORM:  state_next = ST_LOG_SQ;
      ST_LOG_SQ:    if (lrsp.done) state_next = ST_MUL;
      ST_MUL:       state_next = ST_ACC;
      ST_ACC:       state_next = last ? ST_DIV : ST_IDLE;
      ST_DIV:       if (div_done) state_next = ST_FLOG_NORM;
      ST_FLOG_NORM: state_next = ST_FLOG_SQ;
      ST_FLOG_SQ:   if (lrsp.done) state_next = ST_DONE;
      ST_DONE:      state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // unit requests
  always_comb begin
    lreq.start = 1'b0;
    lreq.x     = 64'(cnt);
    div_start  = 1'b0;
    unique case (state)
      ST_LOG_NORM:  lreq.start = 1'b1;
      ST_FLOG_NORM: begin
        lreq.start = 1'b1;
        lreq.x     = 64'(n_acc);
      end
      ST_DIV:       div_start = 1'b1;
      default: ;
    endcase
  end

  assign s_sum = 65'(s_acc) + 65'(term);
  assign n_sum = 41'(n_acc) + 41'(cnt);
  assign h_raw = (64'(lg) > quo_r) ? 64'(lg) - quo_r : 64'd0;
  assign h_rnd = (h_raw + 64'd2) >> 2;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n_acc <= '0;
      s_acc <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      if (state == ST_IDLE && start) begin
        cnt  <= in_word.bin_value[COUNT_BITS-1:0];
        last <= in_word.is_last_bin;
      end
      if (lrsp.done) lg <= lrsp.result;
      if (state == ST_MUL) term <= 64'(cnt) * 64'(lg);
      if (state == ST_ACC) begin
        s_acc <= s_sum[64] ? '1 : s_sum[63:0];
        n_acc <= n_sum[40] ? '1 : n_sum[39:0];
      end
      if (div_done) quo_r <= quo;
      // result word and accumulator clear
      if (state == ST_DONE) begin
        done <= 1'b1;
        out_word.total_count <= n_acc;
        out_word.empty_hist  <= (n_acc == '0);
        if (n_acc == '0) out_word.entropy_bits <= '0;
        else if (h_rnd > 64'hF_FFFF) out_word.entropy_bits <= '1;
        else out_word.entropy_bits <= h_rnd[ENT_BITS-1:0];
        n_acc <= '0;
        s_acc <= '0;
      end
    end
  end

  assign busy = (state != ST_IDLE);

endmodule

@@ rtl/hse_checker.sv @@
module hse_checker (
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic              done,
  input hse_pkg::hse_out_t out_word
);
  import hse_pkg::*;

  // a word taken makes the block busy
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy not raised");

  // done is a single-cycle strobe
  a_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("done longer than a cycle");

  // empty result carries zero entropy and count
  a_empty: assert property (@(posedge clk) disable iff (rst)
    (done && out_word.empty_hist) |->
      (out_word.entropy_bits == '0 && out_word.total_count == '0))
    else $error("empty result not zero");

  // nonempty result has a nonzero count
  a_count: assert property (@(posedge clk) disable iff (rst)
    (done && !out_word.empty_hist) |-> (out_word.total_count != '0))
    else $error("count zero on nonempty result");

endmodule

bind histogram_shannon_entropy hse_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .out_word(out_word)
);
